// ===== hw/rtl/dithered_gouraud_span_shader_core_macros.svh =====
// Assertion macros for the dithered Gouraud span shader.
`ifndef DITHERED_GOURAUD_SPAN_SHADER_CORE_MACROS_SVH
`define DITHERED_GOURAUD_SPAN_SHADER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DGSS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DGSS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/dgss_pkg.sv =====
// Shared types, constants and the dither function of the span shader.
package dgss_pkg;

  localparam int unsigned COL_W      = 10;
  localparam int unsigned COLOR_W    = 16;
  localparam int unsigned LANES      = 16;
  localparam int unsigned LANE_W     = 4;
  localparam int unsigned MAX_GROUPS = 64;
  localparam int unsigned GRP_CNT_W  = 6;

  localparam logic FUNC_SET_STEP = 1'b0;
  localparam logic FUNC_DRAW     = 1'b1;

  localparam logic [1:0] MODE_OFF     = 2'd0;
  localparam logic [1:0] MODE_PLAIN   = 2'd1;
  localparam logic [1:0] MODE_DITHER2 = 2'd2;
  localparam logic [1:0] MODE_DITHER4 = 2'd3;

  // Two-by-two offsets.
  localparam logic [7:0] D2_EVEN_EVEN = 8'(0 << 6);
  localparam logic [7:0] D2_EVEN_ODD  = 8'(2 << 6);
  localparam logic [7:0] D2_ODD_EVEN  = 8'(3 << 6);
  localparam logic [7:0] D2_ODD_ODD   = 8'(1 << 6);

  // Bayer matrix, indexed by {row[1:0], col[1:0]}.
  localparam logic [3:0] BAYER4 [16] = '{
    4'd0,  4'd8,  4'd2,  4'd10,
    4'd12, 4'd4,  4'd14, 4'd6,
    4'd3,  4'd11, 4'd1,  4'd9,
    4'd15, 4'd7,  4'd13, 4'd5
  };

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_DIV  = 6'b000010,
    ST_POST = 6'b000100,
    ST_STEP = 6'b001000,
    ST_PIX  = 6'b010000,
    ST_EMIT = 6'b100000
  } state_e;

  typedef enum logic {
    OP_RECIP = 1'b0,
    OP_ALIGN = 1'b1
  } div_op_e;

  function automatic logic [7:0] dither_offset(logic [1:0] mode, logic [1:0] row,
                                               logic [1:0] col);
    logic [7:0] off;
    off = 8'd0;
    case (mode)
      MODE_DITHER2: begin
        case ({row[0], col[0]})
          2'b00:   off = D2_EVEN_EVEN;
          2'b01:   off = D2_EVEN_ODD;
          2'b10:   off = D2_ODD_EVEN;
          default: off = D2_ODD_ODD;
        endcase
      end
      MODE_DITHER4: off = {4'd15 - BAYER4[{row, col}], 4'd0};
      default:      off = 8'd0;
    endcase
    return off;
  endfunction

endpackage

// ===== hw/rtl/dgss_cfg_if.sv =====
// Configuration write channel carrying the shading mode.
interface dgss_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] shade_mode;

  modport source (output valid, output shade_mode, input ready);
  modport sink   (input valid, input shade_mode, output ready);
endinterface

// ===== hw/rtl/dgss_span_if.sv =====
// Request channel carrying one span or reference item.
interface dgss_span_if;
  logic                             valid;
  logic                             ready;
  logic                             func;
  logic [dgss_pkg::COL_W-1:0]       row;
  logic [dgss_pkg::COL_W-1:0]       start_x;
  logic [dgss_pkg::COL_W-1:0]       end_x;
  logic [dgss_pkg::COLOR_W-1:0]     start_color;
  logic [dgss_pkg::COLOR_W-1:0]     end_color;

  modport source (output valid, output func, output row, output start_x, output end_x,
                  output start_color, output end_color, input ready);
  modport sink   (input valid, input func, input row, input start_x, input end_x,
                  input start_color, input end_color, output ready);
endinterface

// ===== hw/rtl/dgss_group_if.sv =====
// Result channel carrying one pixel group.
interface dgss_group_if;
  logic                         valid;
  logic                         ready;
  logic [dgss_pkg::COL_W-1:0]   out_row;
  logic [dgss_pkg::COL_W-1:0]   group_x;
  logic [63:0]                  pixels_low;
  logic [63:0]                  pixels_high;
  logic [dgss_pkg::LANES-1:0]   byte_enable;
  logic                         last;

  modport source (output valid, output out_row, output group_x, output pixels_low,
                  output pixels_high, output byte_enable, output last, input ready);
  modport sink   (input valid, input out_row, input group_x, input pixels_low,
                  input pixels_high, input byte_enable, input last, output ready);
endinterface

// ===== hw/rtl/dithered_gouraud_span_shader_core.sv =====
// Dithered Gouraud span shader: the sequencer, divider and pixel datapath.
//
// A reference request (func 0) computes the colour step as (end_color - start_color)
// times floor(2^RECIP_FRACT_BITS / width), shifted right by RECIP_FRACT_BITS; the
// reciprocal comes from a restoring divider that produces one quotient bit per cycle.
// A span request (func 1) first rounds start_x down to a group boundary with a
// constant reciprocal multiplication, then walks each group one pixel per cycle
// through the colour adder and hands the group to the output register, waiting there
// whenever the result side stalls; a span yields at most 64 groups.
// Reference requests with a width of zero or less and span requests that produce
// nothing are taken without leaving the idle state. The block takes no new request
// until the current one is finished, but the last group may still wait in the output
// register while the next request is taken.
`include "dithered_gouraud_span_shader_core_macros.svh"

module dithered_gouraud_span_shader_core #(
  parameter int unsigned MAX_SPAN_WIDTH   = 1024,
  parameter int unsigned RECIP_FRACT_BITS = 16,
  parameter int unsigned GROUP_PIXELS     = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  dgss_cfg_if.sink           cfg_i,
  dgss_span_if.sink          span_i,
  dgss_group_if.source       group_o
);

  localparam int unsigned COL_W   = dgss_pkg::COL_W;
  localparam int unsigned COLOR_W = dgss_pkg::COLOR_W;
  localparam int unsigned LANES   = dgss_pkg::LANES;
  localparam int unsigned LANE_W  = dgss_pkg::LANE_W;
  localparam int unsigned WIDTH_W = $clog2(MAX_SPAN_WIDTH);
  localparam int unsigned DVS_W   = WIDTH_W;
  localparam int unsigned CMP_W   = (DVS_W > COL_W) ? DVS_W : COL_W;
  localparam int unsigned RECIP_W = RECIP_FRACT_BITS + 1;
  localparam int unsigned DVD_W   = RECIP_W;
  localparam int unsigned CNT_W   = $clog2(DVD_W + 1);
  localparam int unsigned PROD_W  = RECIP_W + COLOR_W + 2;
  // The start column is divided by the group size through a rounded-up reciprocal;
  // five spare shift bits keep the quotient exact for every column and group size.
  localparam int unsigned ALIGN_SH  = COL_W + 5;
  localparam int unsigned ALIGN_MUL = ((1 << ALIGN_SH) + GROUP_PIXELS - 1) / GROUP_PIXELS;
  localparam int unsigned ALIGN_W   = COL_W + ALIGN_SH + 1;

  // Control state.
  dgss_pkg::state_e             state_q, state_d;
  logic [1:0]                   mode_q, mode_d;
  logic [COLOR_W-1:0]           step_q, step_d;
  logic                         out_valid_q, out_valid_d;

  // Datapath registers.
  dgss_pkg::div_op_e            op_q, op_d;
  logic [COL_W-1:0]             row_q, row_d;
  logic [COL_W-1:0]             sx_q, sx_d;
  logic [COL_W-1:0]             ex_q, ex_d;
  logic signed [COLOR_W:0]      diff_q, diff_d;
  logic [DVS_W-1:0]             dvs_q, dvs_d;
  logic [DVS_W-1:0]             rem_q, rem_d;
  logic [DVD_W-1:0]             dvd_q, dvd_d;
  logic [CNT_W-1:0]             cnt_q, cnt_d;
  logic signed [PROD_W-1:0]     prod_q, prod_d;
  logic [COLOR_W-1:0]           rc_q, rc_d;
  logic [COL_W-1:0]             gx_q, gx_d;
  logic [COL_W:0]               col_q, col_d;
  logic [LANE_W-1:0]            lane_q, lane_d;
  logic [dgss_pkg::GRP_CNT_W-1:0] ngrp_q, ngrp_d;
  logic [7:0]                   pix_q [LANES];
  logic [7:0]                   pix_d [LANES];
  logic [LANES-1:0]             en_q, en_d;

  // Output register.
  logic [COL_W-1:0]             row_out_q, row_out_d;
  logic [COL_W-1:0]             gx_out_q, gx_out_d;
  logic [63:0]                  lo_out_q, lo_out_d;
  logic [63:0]                  hi_out_q, hi_out_d;
  logic [LANES-1:0]             en_out_q, en_out_d;
  logic                         last_out_q, last_out_d;

  // Combinational helpers.
  logic                         span_req;
  logic signed [COL_W:0]        wdiff;
  logic [CMP_W-1:0]             wid_ext;
  logic [CMP_W-1:0]             wid_lim;
  logic [DVS_W:0]               trial;
  logic [DVS_W:0]               trial_sub;
  logic                         trial_ge;
  logic signed [PROD_W-1:0]     mul_a;
  logic signed [PROD_W-1:0]     mul_b;
  logic [ALIGN_W-1:0]           align_prod;
  logic [COL_W-1:0]             grp_idx;
  logic [COL_W-1:0]             grp_base;
  logic                         in_span;
  logic [COLOR_W-1:0]           shaded;
  logic                         slot_free;
  logic                         last_grp;
  logic [63:0]                  lo_pack;
  logic [63:0]                  hi_pack;

  assign cfg_i.ready  = 1'b1;
  assign span_i.ready = (state_q == dgss_pkg::ST_IDLE);
  assign span_req     = span_i.valid && span_i.ready;

  assign group_o.valid       = out_valid_q;
  assign group_o.out_row     = row_out_q;
  assign group_o.group_x     = gx_out_q;
  assign group_o.pixels_low  = lo_out_q;
  assign group_o.pixels_high = hi_out_q;
  assign group_o.byte_enable = en_out_q;
  assign group_o.last        = last_out_q;

  assign wdiff   = $signed({1'b0, span_i.end_x}) - $signed({1'b0, span_i.start_x});
  assign wid_ext = CMP_W'(wdiff[COL_W-1:0]);
  assign wid_lim = CMP_W'(MAX_SPAN_WIDTH - 1);

  // One restoring division step: a quotient bit enters at the bottom of dvd_q.
  assign trial     = {rem_q, dvd_q[DVD_W-1]};
  assign trial_ge  = (trial >= {1'b0, dvs_q});
  assign trial_sub = trial - {1'b0, dvs_q};

  assign mul_a = PROD_W'(dvd_q[RECIP_W-1:0]);
  assign mul_b = PROD_W'(diff_q);

  assign align_prod = ALIGN_W'(sx_q) * ALIGN_W'(ALIGN_MUL);
  assign grp_idx    = align_prod[ALIGN_SH +: COL_W];
  assign grp_base   = COL_W'(grp_idx * GROUP_PIXELS);

  assign in_span   = (col_q >= {1'b0, sx_q}) && (col_q <= {1'b0, ex_q});
  assign shaded    = rc_q + {8'd0, dgss_pkg::dither_offset(mode_q, row_q[1:0], col_q[1:0])};
  assign slot_free = !out_valid_q || group_o.ready;
  // After a full group the column counter sits on the next group's first column.
  assign last_grp  = (col_q > {1'b0, ex_q}) ||
                     (ngrp_q == dgss_pkg::GRP_CNT_W'(dgss_pkg::MAX_GROUPS - 1));

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      lo_pack[8*i +: 8] = pix_q[i];
      hi_pack[8*i +: 8] = pix_q[i+8];
    end
  end

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    op_d        = op_q;
    row_d       = row_q;
    sx_d        = sx_q;
    ex_d        = ex_q;
    diff_d      = diff_q;
    dvs_d       = dvs_q;
    rem_d       = rem_q;
    dvd_d       = dvd_q;
    cnt_d       = cnt_q;
    prod_d      = prod_q;
    rc_d        = rc_q;
    gx_d        = gx_q;
    col_d       = col_q;
    lane_d      = lane_q;
    ngrp_d      = ngrp_q;
    pix_d       = pix_q;
    en_d        = en_q;
    row_out_d   = row_out_q;
    gx_out_d    = gx_out_q;
    lo_out_d    = lo_out_q;
    hi_out_d    = hi_out_q;
    en_out_d    = en_out_q;
    last_out_d  = last_out_q;

    if (cfg_i.valid && cfg_i.ready) begin
      mode_d = cfg_i.shade_mode;
    end

    if (out_valid_q && group_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      dgss_pkg::ST_IDLE: begin
        if (span_req) begin
          row_d  = span_i.row;
          sx_d   = span_i.start_x;
          ex_d   = span_i.end_x;
          diff_d = $signed({1'b0, span_i.end_color}) - $signed({1'b0, span_i.start_color});
          rc_d   = span_i.start_color;
          rem_d  = '0;
          cnt_d  = '0;
          ngrp_d = '0;
          if (span_i.func == dgss_pkg::FUNC_SET_STEP) begin
            op_d  = dgss_pkg::OP_RECIP;
            dvd_d = DVD_W'({1'b1, {RECIP_FRACT_BITS{1'b0}}});
            dvs_d = (wid_ext > wid_lim) ? DVS_W'(wid_lim) : DVS_W'(wid_ext);
            if (wdiff <= 0) begin
              step_d = '0;
            end else begin
              state_d = dgss_pkg::ST_DIV;
            end
          end else begin
            op_d = dgss_pkg::OP_ALIGN;
            if ((mode_q != dgss_pkg::MODE_OFF) && (span_i.end_x >= span_i.start_x)) begin
              state_d = dgss_pkg::ST_POST;
            end
          end
        end
      end
      dgss_pkg::ST_DIV: begin
        rem_d = trial_ge ? trial_sub[DVS_W-1:0] : trial[DVS_W-1:0];
        dvd_d = {dvd_q[DVD_W-2:0], trial_ge};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DVD_W - 1)) begin
          state_d = dgss_pkg::ST_POST;
        end
      end
      dgss_pkg::ST_POST: begin
        if (op_q == dgss_pkg::OP_RECIP) begin
          prod_d  = mul_a * mul_b;
          state_d = dgss_pkg::ST_STEP;
        end else begin
          // The first group starts at start_x rounded down to a multiple of the group size.
          gx_d   = grp_base;
          col_d  = {1'b0, grp_base};
          lane_d = '0;
          en_d   = '0;
          for (int i = 0; i < LANES; i++) begin
            pix_d[i] = 8'd0;
          end
          state_d = dgss_pkg::ST_PIX;
        end
      end
      dgss_pkg::ST_STEP: begin
        // The arithmetic shift rounds toward minus infinity.
        step_d  = prod_q[RECIP_FRACT_BITS +: COLOR_W];
        state_d = dgss_pkg::ST_IDLE;
      end
      dgss_pkg::ST_PIX: begin
        if (in_span) begin
          pix_d[lane_q] = shaded[15:8];
          en_d[lane_q]  = 1'b1;
          rc_d          = rc_q + step_q;
        end
        lane_d = lane_q + 1'b1;
        col_d  = col_q + 1'b1;
        if (lane_q == LANE_W'(GROUP_PIXELS - 1)) begin
          state_d = dgss_pkg::ST_EMIT;
        end
      end
      dgss_pkg::ST_EMIT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          row_out_d   = row_q;
          gx_out_d    = gx_q;
          lo_out_d    = lo_pack;
          hi_out_d    = hi_pack;
          en_out_d    = en_q;
          last_out_d  = last_grp;
          if (last_grp) begin
            state_d = dgss_pkg::ST_IDLE;
          end else begin
            gx_d   = col_q[COL_W-1:0];
            lane_d = '0;
            ngrp_d = ngrp_q + 1'b1;
            en_d   = '0;
            for (int i = 0; i < LANES; i++) begin
              pix_d[i] = 8'd0;
            end
            state_d = dgss_pkg::ST_PIX;
          end
        end
      end
      default: begin
        state_d = dgss_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dgss_pkg::ST_IDLE;
      mode_q      <= dgss_pkg::MODE_DITHER4;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    row_q      <= row_d;
    sx_q       <= sx_d;
    ex_q       <= ex_d;
    diff_q     <= diff_d;
    dvs_q      <= dvs_d;
    rem_q      <= rem_d;
    dvd_q      <= dvd_d;
    cnt_q      <= cnt_d;
    prod_q     <= prod_d;
    rc_q       <= rc_d;
    gx_q       <= gx_d;
    col_q      <= col_d;
    lane_q     <= lane_d;
    ngrp_q     <= ngrp_d;
    pix_q      <= pix_d;
    en_q       <= en_d;
    row_out_q  <= row_out_d;
    gx_out_q   <= gx_out_d;
    lo_out_q   <= lo_out_d;
    hi_out_q   <= hi_out_d;
    en_out_q   <= en_out_d;
    last_out_q <= last_out_d;
  end

  // A group only enters the output register from the hand-over state.
  `DGSS_ASSERT_NXT(a_load_from_emit, clk_i, rst_ni,
                   !out_valid_q && (state_q != dgss_pkg::ST_EMIT), !out_valid_q,
                   "group presented outside hand-over")
  // Drawing a span never disturbs the colour step.
  `DGSS_ASSERT_NXT(a_draw_keeps_step, clk_i, rst_ni,
                   span_req && (span_i.func == dgss_pkg::FUNC_DRAW), $stable(step_q),
                   "colour step changed by a span request")
  // Every group that is presented covers at least one pixel of its span.
  `DGSS_ASSERT_IMP(a_group_not_empty, clk_i, rst_ni, out_valid_q, en_out_q != '0,
                   "empty pixel group presented")

endmodule
